// ===== hw/rtl/hfq_pkg.sv =====
// Shared widths, codes and limits for the heightfield height query block.
package hfq_pkg;

    localparam int POS_W   = 32;
    localparam int HGT_W   = 32;
    localparam int SCALE_W = 24;
    localparam int GRID_W  = 5;
    localparam int CFG_IDX_W = 2;

    // Vertices along each side of the grid; the grid coordinate ports are sized for it.
    localparam int GRID_POINTS = 21;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 24'd65536;

    // Barycentric weights are limited to +-4096 grid units in Q.16.
    localparam logic signed [63:0] AB_LIMIT = 64'sd268435456;
    // The interpolated height is limited to +-2^22 in Q16.16.
    localparam logic signed [63:0] Y_LIMIT  = 64'sd274877906944;

    localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

endpackage

// ===== hw/rtl/heightfield_triangle_height_query.sv =====
// Heightfield triangle height query: banked height grid and a ten-stage query pipeline.
//
// The block keeps a GRID_POINTS x GRID_POINTS grid of signed Q16.16 vertex heights and
// answers height queries at world positions. A request with opcode write stores one
// height; a request with opcode query scales the position by the reciprocal scale
// registers, locates the grid cell (clamping it into the grid and raising out_of_range
// when it had to), picks one of the cell's two triangles, evaluates its plane and scales
// the result by scale_y. The block accepts one request every clock cycle while the
// output side does not stall, writes and queries mixed freely. The rate is set by the
// height memory: the grid is split into four banks by the parity of the vertex column
// and row, so the four corners of any cell sit in four different banks and are read in
// the same cycle. Writes travel down the same pipeline and update their bank at the
// stage where queries read, so requests observe each other strictly in order without
// forwarding. The heights are undefined until they are written, and there is no
// clearing pass after reset. A stall on the output while a result is held there stops
// the whole pipeline and is passed back on in_stall in the same cycle. Configuration
// writes must only be issued while no query is in flight.
module heightfield_triangle_height_query (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [hfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hfq_pkg::SCALE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [hfq_pkg::GRID_W-1:0]          grid_x,
    input  logic [hfq_pkg::GRID_W-1:0]          grid_z,
    input  logic signed [hfq_pkg::HGT_W-1:0]    height_in,
    input  logic signed [hfq_pkg::POS_W-1:0]    pos_x,
    input  logic signed [hfq_pkg::POS_W-1:0]    pos_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [hfq_pkg::HGT_W-1:0]    height_out,
    output logic                                out_of_range
);
    import hfq_pkg::*;

    localparam int CENTER     = (GRID_POINTS - 1) / 2;
    localparam int HALF       = (GRID_POINTS + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int IW         = $clog2(GRID_POINTS);
    localparam logic signed [63:0] CENTER_FX = signed'(64'(CENTER) << 32);
    localparam logic signed [32:0] MAX_CELL  = 33'(GRID_POINTS - 2);

    // Configuration registers.
    logic [SCALE_W-1:0] inv_scale_x_reg;
    logic [SCALE_W-1:0] inv_scale_z_reg;
    logic [SCALE_W-1:0] scale_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_x_reg <= SCALE_ONE;
            inv_scale_z_reg <= SCALE_ONE;
            scale_y_reg     <= SCALE_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INV_SCALE_X: inv_scale_x_reg <= cfg_data;
                CFG_INV_SCALE_Z: inv_scale_z_reg <= cfg_data;
                CFG_SCALE_Y:     scale_y_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The whole pipeline moves together; only a held result stops it.
    logic advance;
    logic out_valid_reg;
    logic [9:1] vld_reg;
    logic [4:1] op_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[1] <= in_valid;
            op_reg[1]  <= opcode;
            vld_reg[4:2] <= vld_reg[3:1];
            op_reg[4:2]  <= op_reg[3:1];
            // From stage five on only queries are tracked.
            vld_reg[5] <= vld_reg[4] && (op_reg[4] == OP_QUERY);
            vld_reg[9:6] <= vld_reg[8:5];
            out_valid_reg <= vld_reg[9];
        end
    end

    // Stage 1: captured request.
    logic [GRID_W-1:0]        s1_gx_reg, s1_gz_reg;
    logic signed [HGT_W-1:0]  s1_hgt_reg;
    logic signed [POS_W-1:0]  s1_px_reg, s1_pz_reg;

    // Write address, bank and data travel to the memory stage.
    logic              wr_ok_next;
    logic [1:0]        wr_bank_next;
    logic [AW-1:0]     wr_addr_next;
    logic [4:2]        wr_ok_reg;
    logic [1:0]        wr_bank_reg [4:2];
    logic [AW-1:0]     wr_addr_reg [4:2];
    logic signed [HGT_W-1:0] wr_data_reg [4:2];

    assign wr_ok_next   = ({27'd0, s1_gx_reg} < 32'(GRID_POINTS))
                       && ({27'd0, s1_gz_reg} < 32'(GRID_POINTS));
    assign wr_bank_next = {s1_gx_reg[0], s1_gz_reg[0]};
    assign wr_addr_next = AW'(int'(s1_gx_reg >> 1) * HALF + int'(s1_gz_reg >> 1));

    // Stage 2: position times reciprocal scale.
    logic signed [56:0] s2_px_reg, s2_pz_reg;
    logic signed [56:0] px_next, pz_next;

    assign px_next = s1_px_reg * $signed({1'b0, inv_scale_x_reg});
    assign pz_next = s1_pz_reg * $signed({1'b0, inv_scale_z_reg});

    // Stage 3: grid coordinates with 32 fraction bits.
    logic signed [63:0] s3_gx_reg, s3_gz_reg;
    logic signed [63:0] gx_next, gz_next, px_w, pz_w;

    assign px_w    = 64'(s2_px_reg);
    assign pz_w    = 64'(s2_pz_reg);
    assign gx_next = CENTER_FX + (px_w <<< 4) + (px_w <<< 2);
    assign gz_next = CENTER_FX - (pz_w <<< 4) - (pz_w <<< 2);

    // Stage 4: cell index, truncated toward zero and clamped.
    logic signed [63:0] s4_gx_reg, s4_gz_reg;
    logic [IW-1:0]      s4_ci_reg, s4_cj_reg;
    logic               s4_clamp_reg;
    logic signed [32:0] tx, tz;
    logic [IW-1:0]      ci_next, cj_next;
    logic               clx, clz;

    always_comb
    begin
        tx = 33'(s3_gx_reg >>> 32)
           + ((s3_gx_reg < 0 && s3_gx_reg[31:0] != 32'd0) ? 33'sd1 : 33'sd0);
        tz = 33'(s3_gz_reg >>> 32)
           + ((s3_gz_reg < 0 && s3_gz_reg[31:0] != 32'd0) ? 33'sd1 : 33'sd0);
        clx = 1'b1;
        clz = 1'b1;
        if (tx < 0)
            ci_next = '0;
        else if (tx > MAX_CELL)
            ci_next = IW'(GRID_POINTS - 2);
        else
        begin
            ci_next = tx[IW-1:0];
            clx = 1'b0;
        end
        if (tz < 0)
            cj_next = '0;
        else if (tz > MAX_CELL)
            cj_next = IW'(GRID_POINTS - 2);
        else
        begin
            cj_next = tz[IW-1:0];
            clz = 1'b0;
        end
    end

    // Stage 5: weights, triangle choice and corner reads.
    logic signed [63:0] a32, b32, a_fl, b_fl;
    logic signed [29:0] a_next, b_next;
    logic [IW-1:0]      ci_p1, cj_p1;
    logic [AW-1:0]      rd_addr [4];
    logic signed [29:0] s5_a_reg, s5_b_reg;
    logic               s5_sel_reg, s5_cx_reg, s5_cz_reg, s5_clamp_reg;
    logic signed [HGT_W-1:0] rd_data_reg [4];

    assign ci_p1 = s4_ci_reg + IW'(1);
    assign cj_p1 = s4_cj_reg + IW'(1);

    always_comb
    begin
        a32  = s4_gx_reg - signed'(64'(ci_p1) << 32);
        b32  = signed'(64'(s4_cj_reg) << 32) - s4_gz_reg;
        a_fl = a32 >>> 16;
        b_fl = b32 >>> 16;
        if (a_fl > AB_LIMIT)
            a_next = 30'(AB_LIMIT);
        else if (a_fl < -AB_LIMIT)
            a_next = 30'(-AB_LIMIT);
        else
            a_next = 30'(a_fl);
        if (b_fl > AB_LIMIT)
            b_next = 30'(AB_LIMIT);
        else if (b_fl < -AB_LIMIT)
            b_next = 30'(-AB_LIMIT);
        else
            b_next = 30'(b_fl);
    end

    // Bank {px, pz} holds the vertices whose column has parity px and row parity pz.
    for (genvar bk = 0; bk < 4; bk++)
    begin : g_bank
        logic [HGT_W-1:0] mem [BANK_DEPTH];
        logic [IW-1:0]    xs, zs;
        logic             wr_here;

        assign xs = (s4_ci_reg[0] == 1'(bk >> 1)) ? s4_ci_reg : ci_p1;
        assign zs = (s4_cj_reg[0] == 1'(bk)) ? s4_cj_reg : cj_p1;
        assign rd_addr[bk] = AW'(int'(xs[IW-1:1]) * HALF + int'(zs[IW-1:1]));
        assign wr_here = advance && vld_reg[4] && (op_reg[4] == OP_WRITE)
                      && wr_ok_reg[4] && (wr_bank_reg[4] == 2'(bk));

        always_ff @(posedge clk)
        begin
            if (wr_here)
                mem[wr_addr_reg[4]] <= wr_data_reg[4];
            if (advance)
                rd_data_reg[bk] <= signed'(mem[rd_addr[bk]]);
        end
    end

    // Stage 6: edge differences of the chosen triangle.
    logic signed [HGT_W-1:0] h00, h10, h01, h11;
    logic signed [32:0]      da_next, db_next;
    logic signed [32:0]      s6_da_reg, s6_db_reg;
    logic signed [29:0]      s6_a_reg, s6_b_reg;
    logic signed [HGT_W-1:0] s6_h10_reg;
    logic                    s6_clamp_reg;

    always_comb
    begin
        h00 = rd_data_reg[{s5_cx_reg,  s5_cz_reg}];
        h10 = rd_data_reg[{!s5_cx_reg, s5_cz_reg}];
        h01 = rd_data_reg[{s5_cx_reg,  !s5_cz_reg}];
        h11 = rd_data_reg[{!s5_cx_reg, !s5_cz_reg}];
        if (s5_sel_reg)
        begin
            da_next = 33'(h10) - 33'(h00);
            db_next = 33'(h00) - 33'(h01);
        end
        else
        begin
            da_next = 33'(h11) - 33'(h01);
            db_next = 33'(h10) - 33'(h11);
        end
    end

    // Stage 7: weighted differences.
    logic signed [63:0]      s7_pa_reg, s7_pb_reg;
    logic signed [HGT_W-1:0] s7_h10_reg;
    logic                    s7_clamp_reg;
    logic signed [62:0]      pa_next, pb_next;

    assign pa_next = s6_a_reg * s6_da_reg;
    assign pb_next = s6_b_reg * s6_db_reg;

    // Stage 8: plane height in Q16.16, saturated.
    logic signed [63:0] ysum, yfl;
    logic signed [39:0] y_next, s8_y_reg;
    logic               s8_clamp_reg;

    always_comb
    begin
        ysum = s7_pa_reg + s7_pb_reg + (64'(s7_h10_reg) <<< 16);
        yfl  = ysum >>> 16;
        if (yfl > Y_LIMIT)
            y_next = 40'(Y_LIMIT);
        else if (yfl < -Y_LIMIT)
            y_next = 40'(-Y_LIMIT);
        else
            y_next = 40'(yfl);
    end

    // Stage 9: world scale.
    logic signed [64:0] ys_next;
    logic signed [63:0] s9_ys_reg;
    logic               s9_clamp_reg;

    assign ys_next = s8_y_reg * $signed({1'b0, scale_y_reg});

    // Stage 10: output register.
    logic signed [63:0]      r_fl;
    logic signed [HGT_W-1:0] r_next;
    logic signed [HGT_W-1:0] height_out_reg;
    logic                    out_of_range_reg;

    always_comb
    begin
        r_fl = s9_ys_reg >>> 16;
        if (r_fl > OUT_MAX)
            r_next = HGT_W'(OUT_MAX);
        else if (r_fl < OUT_MIN)
            r_next = HGT_W'(OUT_MIN);
        else
            r_next = HGT_W'(r_fl);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_gx_reg  <= grid_x;
            s1_gz_reg  <= grid_z;
            s1_hgt_reg <= height_in;
            s1_px_reg  <= pos_x;
            s1_pz_reg  <= pos_z;

            wr_ok_reg[2]   <= wr_ok_next;
            wr_bank_reg[2] <= wr_bank_next;
            wr_addr_reg[2] <= wr_addr_next;
            wr_data_reg[2] <= s1_hgt_reg;
            for (int k = 3; k <= 4; k++)
            begin
                wr_ok_reg[k]   <= wr_ok_reg[k-1];
                wr_bank_reg[k] <= wr_bank_reg[k-1];
                wr_addr_reg[k] <= wr_addr_reg[k-1];
                wr_data_reg[k] <= wr_data_reg[k-1];
            end

            s2_px_reg <= px_next;
            s2_pz_reg <= pz_next;

            s3_gx_reg <= gx_next;
            s3_gz_reg <= gz_next;

            s4_gx_reg    <= s3_gx_reg;
            s4_gz_reg    <= s3_gz_reg;
            s4_ci_reg    <= ci_next;
            s4_cj_reg    <= cj_next;
            s4_clamp_reg <= clx || clz;

            s5_a_reg     <= a_next;
            s5_b_reg     <= b_next;
            s5_sel_reg   <= (b32 > a32);
            s5_cx_reg    <= s4_ci_reg[0];
            s5_cz_reg    <= s4_cj_reg[0];
            s5_clamp_reg <= s4_clamp_reg;

            s6_da_reg    <= da_next;
            s6_db_reg    <= db_next;
            s6_a_reg     <= s5_a_reg;
            s6_b_reg     <= s5_b_reg;
            s6_h10_reg   <= h10;
            s6_clamp_reg <= s5_clamp_reg;

            s7_pa_reg    <= 64'(pa_next);
            s7_pb_reg    <= 64'(pb_next);
            s7_h10_reg   <= s6_h10_reg;
            s7_clamp_reg <= s6_clamp_reg;

            s8_y_reg     <= y_next;
            s8_clamp_reg <= s7_clamp_reg;

            s9_ys_reg    <= 64'(ys_next);
            s9_clamp_reg <= s8_clamp_reg;

            height_out_reg   <= r_next;
            out_of_range_reg <= s9_clamp_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign height_out   = height_out_reg;
    assign out_of_range = out_of_range_reg;

endmodule
